### hw/rtl/otm_pkg.sv
// ----------------------------------------------------------------------------
// OS timer package
// Shared types, register codes and sizes for the OS timer with match
// channels and watchdog.
// ----------------------------------------------------------------------------
package otm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int MAX_CHANNELS = 4;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [2:0] REG_MATCH0 = 3'd0;
    localparam logic [2:0] REG_MATCH1 = 3'd1;
    localparam logic [2:0] REG_MATCH2 = 3'd2;
    localparam logic [2:0] REG_MATCH3 = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;
    localparam logic [2:0] REG_STATUS = 3'd5;
    localparam logic [2:0] REG_WDOG   = 3'd6;
    localparam logic [2:0] REG_IRQEN  = 3'd7;

    localparam logic [15:0] TICK_DIV_RESET = 16'd1;

    typedef logic [31:0]             word_t;
    typedef logic [MAX_CHANNELS-1:0] chan_mask_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  irq_lines;
        logic        reset_request;
        logic        access_error;
    } rsp_t;

    typedef struct packed {
        chan_mask_t irq_enable;
        chan_mask_t match_status;
    } chan_ctrl_t;

endpackage

### hw/rtl/otm_req_if.sv
// ----------------------------------------------------------------------------
// OS timer request channel
// Valid/ready channel that carries one tick or bus access per transfer.
// ----------------------------------------------------------------------------
interface otm_req_if
    import otm_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/otm_rsp_if.sv
// ----------------------------------------------------------------------------
// OS timer response channel
// Valid/ready channel that carries one result per request transfer.
// ----------------------------------------------------------------------------
interface otm_rsp_if
    import otm_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/os_timer_match_watchdog.sv
// ----------------------------------------------------------------------------
// OS timer with match channels and watchdog
// Free-running counter with prescaler, four match channels, sticky status,
// interrupt enables and a write-once watchdog, behind eight word registers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_ch    in         tick, read or write: req_type, offset, size, data
//  rsp_ch    out        read_data, irq_lines, reset_request, access_error
//  cfg       in         tick_divider write (cfg_we, cfg_wdata)
//
// Each transfer is handled in the cycle it is accepted; its result appears in
// the output register on the next cycle, and one transfer per cycle is
// sustained. The request side stalls only while a result waits and the
// response side is not ready. Reset clears all timer state and sets the
// divider to one.
// ----------------------------------------------------------------------------
module os_timer_match_watchdog
    import otm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    otm_req_if.sink     req_ch,
    otm_rsp_if.source   rsp_ch
);

    logic [15:0] tick_div_reg;
    word_t       count_reg, count_next;
    logic [15:0] prescale_reg, prescale_next;
    word_t       match_reg [MAX_CHANNELS];
    word_t       match_next [MAX_CHANNELS];
    word_t       anchor_reg [MAX_CHANNELS];
    word_t       anchor_next [MAX_CHANNELS];
    chan_mask_t  status_reg, status_next;
    logic        wdog_reg, wdog_next;
    chan_mask_t  irq_en_reg, irq_en_next;
    chan_mask_t  irq_reg, irq_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_data_reg, rsp_data_next;

    logic        accept;
    req_t        req;
    logic [2:0]  word_idx;
    logic [4:0]  shift;
    word_t       size_mask;
    word_t       cur_word;
    word_t       wr_word;
    logic        decode_ok;
    logic [15:0] divider;
    logic [15:0] prescale_inc;
    word_t       count_tick;
    chan_mask_t  hit;
    chan_mask_t  cleared;
    logic        wdog_hit;
    chan_ctrl_t  chan_ctrl;

    assign req    = req_ch.data;
    assign accept = req_ch.valid && req_ch.ready;
    assign req_ch.ready = !rsp_valid_reg || rsp_ch.ready;
    assign rsp_ch.valid = rsp_valid_reg;
    assign rsp_ch.data  = rsp_data_reg;

    assign word_idx  = req.offset[4:2];
    assign shift     = {req.offset[1:0], 3'b000};
    assign decode_ok = (req.offset[15:5] == 11'd0);

    always_comb
    begin
        case (req.access_size)
            SIZE_HALF: size_mask = 32'h0000_FFFF;
            SIZE_WORD: size_mask = 32'hFFFF_FFFF;
            default:   size_mask = 32'h0000_00FF;
        endcase
    end

    always_comb
    begin
        case (word_idx)
            REG_MATCH0: cur_word = match_reg[0];
            REG_MATCH1: cur_word = match_reg[1];
            REG_MATCH2: cur_word = match_reg[2];
            REG_MATCH3: cur_word = match_reg[3];
            REG_COUNT:  cur_word = count_reg;
            REG_STATUS: cur_word = {28'd0, status_reg};
            REG_WDOG:   cur_word = {31'd0, wdog_reg};
            REG_IRQEN:  cur_word = {28'd0, irq_en_reg};
            default:    cur_word = 32'd0;
        endcase
    end

    assign wr_word = (req.access_size == SIZE_WORD) ? req.write_data
                   : ((cur_word & ~(size_mask << shift))
                      | ((req.write_data & size_mask) << shift));

    assign divider      = (tick_div_reg == 16'd0) ? 16'd1 : tick_div_reg;
    assign prescale_inc = prescale_reg + 16'd1;
    assign count_tick   = (prescale_inc >= divider) ? count_reg + 32'd1 : count_reg;

    assign chan_ctrl.irq_enable   = irq_en_reg;
    assign chan_ctrl.match_status = status_reg;

    otm_match_unit u_match (
        .count_value (count_tick),
        .match_value (match_reg),
        .arm_anchor  (anchor_reg),
        .ctrl        (chan_ctrl),
        .hit         (hit)
    );

    assign wdog_hit = hit[MAX_CHANNELS-1] && wdog_reg;
    assign cleared  = status_reg & wr_word[MAX_CHANNELS-1:0];

    always_comb
    begin
        count_next    = count_reg;
        prescale_next = prescale_reg;
        match_next    = match_reg;
        anchor_next   = anchor_reg;
        status_next   = status_reg;
        wdog_next     = wdog_reg;
        irq_en_next   = irq_en_reg;
        irq_next      = irq_reg;
        rsp_data_next = rsp_data_reg;

        if (accept)
        begin
            rsp_data_next.read_data     = 32'd0;
            rsp_data_next.reset_request = 1'b0;
            rsp_data_next.access_error  = 1'b0;
            case (req.req_type)
                REQ_TICK:
                begin
                    prescale_next = (prescale_inc >= divider) ? 16'd0 : prescale_inc;
                    count_next    = count_tick;
                    status_next   = status_reg | hit;
                    rsp_data_next.reset_request = wdog_hit;
                    if (!wdog_hit)
                    begin
                        irq_next = irq_reg | hit;
                    end
                end
                REQ_READ:
                begin
                    rsp_data_next.access_error = !decode_ok;
                    if (decode_ok)
                    begin
                        rsp_data_next.read_data = (cur_word >> shift) & size_mask;
                    end
                end
                REQ_WRITE:
                begin
                    rsp_data_next.access_error = !decode_ok;
                    if (decode_ok)
                    begin
                        case (word_idx)
                            REG_MATCH0, REG_MATCH1, REG_MATCH2, REG_MATCH3:
                            begin
                                match_next[word_idx[1:0]]  = wr_word;
                                anchor_next[word_idx[1:0]] = count_reg;
                            end
                            REG_COUNT:
                            begin
                                count_next    = wr_word;
                                prescale_next = 16'd0;
                            end
                            REG_STATUS:
                            begin
                                status_next = status_reg & ~cleared;
                                irq_next    = irq_reg & ~cleared;
                                for (int n = 0; n < MAX_CHANNELS; n++)
                                begin
                                    if (cleared[n])
                                    begin
                                        anchor_next[n] = count_reg;
                                    end
                                end
                            end
                            REG_WDOG:
                            begin
                                wdog_next = wdog_reg | wr_word[0];
                            end
                            REG_IRQEN:
                            begin
                                irq_en_next = wr_word[MAX_CHANNELS-1:0];
                            end
                            default:
                            begin
                                wdog_next = wdog_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    rsp_data_next.read_data = 32'd0;
                end
            endcase
            rsp_data_next.irq_lines = irq_next;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_div_reg  <= TICK_DIV_RESET;
            count_reg     <= '0;
            prescale_reg  <= '0;
            match_reg     <= '{default: '0};
            anchor_reg    <= '{default: '0};
            status_reg    <= '0;
            wdog_reg      <= 1'b0;
            irq_en_reg    <= '0;
            irq_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tick_div_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            prescale_reg  <= prescale_next;
            match_reg     <= match_next;
            anchor_reg    <= anchor_next;
            status_reg    <= status_next;
            wdog_reg      <= wdog_next;
            irq_en_reg    <= irq_en_next;
            irq_reg       <= irq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

endmodule

### hw/rtl/otm_match_unit.sv
// ----------------------------------------------------------------------------
// OS timer match unit
// Forward-crossing test of every enabled, idle channel against the counter.
// ----------------------------------------------------------------------------
module otm_match_unit
    import otm_pkg::*;
(
    input  word_t      count_value,
    input  word_t      match_value [MAX_CHANNELS],
    input  word_t      arm_anchor [MAX_CHANNELS],
    input  chan_ctrl_t ctrl,
    output chan_mask_t hit
);

    word_t elapsed  [MAX_CHANNELS];
    word_t distance [MAX_CHANNELS];

    always_comb
    begin
        for (int n = 0; n < MAX_CHANNELS; n++)
        begin
            elapsed[n]  = count_value - arm_anchor[n];
            distance[n] = match_value[n] - arm_anchor[n];
            hit[n] = (n < NUM_CHANNELS) && ctrl.irq_enable[n] && !ctrl.match_status[n]
                     && (elapsed[n] >= distance[n]);
        end
    end

endmodule

### sim/tb_os_timer_match_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OS timer with match channels and watchdog: testbench
// Drives ticks and bus reads and writes through the valid/ready request
// channel and checks every response against a scoreboard that tracks the
// counter, prescaler, match channels, status, interrupts and watchdog.
// Several divider settings and idle patterns are used, the watchdog is
// enabled late in the run, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_os_timer_match_watchdog;

    import otm_pkg::*;

    localparam logic [1:0] REQ_IDLE     = 2'd3;
    localparam logic [1:0] SIZE_ODD     = 2'd3;
    localparam int         WDOG_CHANNEL = 3;
    localparam int         HOLD_CYCLES  = 300;

    class timer_scoreboard;
        logic [15:0] divider;
        word_t       counter;
        logic [15:0] prescale;
        word_t       match_val [MAX_CHANNELS];
        word_t       anchor [MAX_CHANNELS];
        chan_mask_t  status;
        chan_mask_t  irq_en;
        chan_mask_t  irq_act;
        logic        wdog_en;
        rsp_t        expected_rsp [$];
        int          mismatches;
        int          n_ticks;
        int          n_reads;
        int          n_writes;
        int          n_idle;
        int          n_decode_err;
        int          n_hits;
        int          n_resets;

        function new();
            divider      = TICK_DIV_RESET;
            counter      = '0;
            prescale     = '0;
            status       = '0;
            irq_en       = '0;
            irq_act      = '0;
            wdog_en      = 1'b0;
            mismatches   = 0;
            n_ticks      = 0;
            n_reads      = 0;
            n_writes     = 0;
            n_idle       = 0;
            n_decode_err = 0;
            n_hits       = 0;
            n_resets     = 0;
            foreach (match_val[i])
            begin
                match_val[i] = '0;
                anchor[i]    = '0;
            end
        endfunction

        function word_t read_reg(logic [2:0] idx);
            case (idx)
                REG_MATCH0, REG_MATCH1, REG_MATCH2, REG_MATCH3: return match_val[idx[1:0]];
                REG_COUNT:  return counter;
                REG_STATUS: return 32'(status);
                REG_WDOG:   return 32'(wdog_en);
                default:    return 32'(irq_en);
            endcase
        endfunction

        function void write_reg(logic [2:0] idx, word_t v);
            chan_mask_t cleared;
            case (idx)
                REG_MATCH0, REG_MATCH1, REG_MATCH2, REG_MATCH3:
                begin
                    match_val[idx[1:0]] = v;
                    anchor[idx[1:0]]    = counter;
                end
                REG_COUNT:
                begin
                    counter  = v;
                    prescale = '0;
                end
                REG_STATUS:
                begin
                    cleared = status & v[3:0];
                    status  = status & ~v[3:0];
                    for (int n = 0; n < MAX_CHANNELS; n++)
                    begin
                        if (cleared[n])
                        begin
                            anchor[n]  = counter;
                            irq_act[n] = 1'b0;
                        end
                    end
                end
                REG_WDOG:   wdog_en = wdog_en | v[0];
                default:    irq_en = v[3:0];
            endcase
        endfunction

        function logic advance_tick();
            logic [15:0] div;
            chan_mask_t  fresh;
            logic        wd_hit;
            div      = (divider == '0) ? 16'd1 : divider;
            fresh    = '0;
            wd_hit   = 1'b0;
            prescale = prescale + 16'd1;
            if (prescale >= div)
            begin
                prescale = '0;
                counter  = counter + 32'd1;
            end
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                if (irq_en[n] && !status[n] &&
                    (counter - anchor[n]) >= (match_val[n] - anchor[n]))
                begin
                    status[n] = 1'b1;
                    fresh[n]  = 1'b1;
                    if (n == WDOG_CHANNEL && wdog_en)
                        wd_hit = 1'b1;
                end
            end
            if (!wd_hit)
                irq_act = irq_act | fresh;
            n_hits += $countones(fresh);
            if (wd_hit)
                n_resets++;
            return wd_hit;
        endfunction

        function void note_request(req_t r);
            rsp_t       e;
            logic [2:0] idx;
            int         shift;
            word_t      mask;
            word_t      cur;
            e     = '0;
            idx   = r.offset[4:2];
            shift = 8 * r.offset[1:0];
            case (r.access_size)
                SIZE_WORD: mask = 32'hFFFF_FFFF;
                SIZE_HALF: mask = 32'h0000_FFFF;
                default:   mask = 32'h0000_00FF;
            endcase
            case (r.req_type)
                REQ_TICK:
                begin
                    n_ticks++;
                    e.reset_request = advance_tick();
                end
                REQ_READ, REQ_WRITE:
                begin
                    if (r.req_type == REQ_READ)
                        n_reads++;
                    else
                        n_writes++;
                    if (r.offset[15:5] != '0)
                    begin
                        e.access_error = 1'b1;
                        n_decode_err++;
                    end
                    else if (r.req_type == REQ_READ)
                        e.read_data = (read_reg(idx) >> shift) & mask;
                    else if (r.access_size == SIZE_WORD)
                        write_reg(idx, r.write_data);
                    else
                    begin
                        cur = read_reg(idx);
                        write_reg(idx, (cur & ~(mask << shift)) |
                                       ((r.write_data & mask) << shift));
                    end
                end
                default: n_idle++;
            endcase
            e.irq_lines = irq_act;
            expected_rsp.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                $error("response transfer with no expected response waiting");
                mismatches++;
                return;
            end
            e = expected_rsp.pop_front();
            if (got.read_data !== e.read_data)
            begin
                $error("read_data: expected %h, actual %h", e.read_data, got.read_data);
                mismatches++;
            end
            if (got.irq_lines !== e.irq_lines)
            begin
                $error("irq_lines: expected %h, actual %h", e.irq_lines, got.irq_lines);
                mismatches++;
            end
            if (got.reset_request !== e.reset_request)
            begin
                $error("reset_request: expected %b, actual %b",
                       e.reset_request, got.reset_request);
                mismatches++;
            end
            if (got.access_error !== e.access_error)
            begin
                $error("access_error: expected %b, actual %b",
                       e.access_error, got.access_error);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    otm_req_if req_ch ();
    otm_rsp_if rsp_ch ();

    timer_scoreboard scoreboard = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int divider_writes = 0;

    os_timer_match_watchdog uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            scoreboard.check_response(rsp_ch.data);
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [15:0] reg_offset(logic [2:0] idx);
        return {11'd0, idx, 2'b00};
    endfunction

    function automatic req_t random_request(bit wdog_ok);
        req_t r;
        int   pick;
        pick = $urandom_range(0, 19);
        r.req_type = (pick < 8) ? REQ_TICK : (pick < 13) ? REQ_READ :
                     (pick < 19) ? REQ_WRITE : REQ_IDLE;
        r.offset = ($urandom_range(0, 6) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 31));
        r.access_size = ($urandom_range(0, 9) == 0) ? SIZE_ODD : 2'($urandom_range(0, 2));
        r.write_data = ($urandom_range(0, 1) == 1) ? $urandom() : 32'($urandom_range(0, 15));
        if (!wdog_ok && r.offset[15:5] == '0 && r.offset[4:2] == REG_WDOG)
            r.write_data[0] = 1'b0;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        scoreboard.note_request(r);
        items_sent++;
    endtask

    task automatic issue(logic [1:0] kind, logic [15:0] off, logic [1:0] size, word_t data);
        req_t r;
        r.req_type    = kind;
        r.offset      = off;
        r.access_size = size;
        r.write_data  = data;
        send_request(r);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (scoreboard.expected_rsp.size() != 0);
    endtask

    task automatic set_divider(logic [15:0] div);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= div;
        @(posedge clk);
        cfg_we <= 1'b0;
        scoreboard.divider = div;
        divider_writes++;
    endtask

    // One armed channel: enable it, set its match a few counts ahead, tick
    // toward it, look at status and usually clear it again.
    task automatic run_match_episode(bit wdog_ok);
        int         ch;
        chan_mask_t en;
        ch     = $urandom_range(0, NUM_CHANNELS - 1);
        en     = chan_mask_t'($urandom());
        en[ch] = 1'b1;
        issue(REQ_WRITE, reg_offset(REG_IRQEN), SIZE_WORD, 32'(en));
        issue(REQ_WRITE, reg_offset(REG_MATCH0 + 3'(ch)), SIZE_WORD,
              scoreboard.counter + 32'($urandom_range(0, 6)));
        repeat ($urandom_range(2, 24))
        begin
            if ($urandom_range(0, 5) == 0)
                send_request(random_request(wdog_ok));
            else
                issue(REQ_TICK, 16'($urandom()), 2'($urandom()), $urandom());
        end
        issue(REQ_READ, reg_offset(REG_STATUS), SIZE_WORD, $urandom());
        if ($urandom_range(0, 3) != 0)
            issue(REQ_WRITE, reg_offset(REG_STATUS) + 16'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)),
                  ($urandom_range(0, 1) == 1) ? 32'(1 << ch) : $urandom());
    endtask

    task automatic run_random(int count, bit wdog_ok);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 2) != 0)
                run_match_episode(wdog_ok);
            else
                send_request(random_request(wdog_ok));
        end
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_divider(16'd1);
        issue(REQ_WRITE, reg_offset(REG_MATCH0), SIZE_WORD, 32'hFFFF_FFFF);
        issue(REQ_READ, reg_offset(REG_MATCH0) + 16'd3, SIZE_BYTE, 32'h0);
        issue(REQ_WRITE, reg_offset(REG_MATCH1) + 16'd2, SIZE_HALF, 32'h1234_ABCD);
        issue(REQ_READ, reg_offset(REG_MATCH1), SIZE_WORD, 32'h0);
        issue(REQ_WRITE, reg_offset(REG_COUNT) + 16'd1, SIZE_BYTE, 32'hFFFF_FF5A);
        issue(REQ_READ, reg_offset(REG_COUNT) + 16'd2, SIZE_HALF, 32'h0);
        // The counter sits just below the wrap so that channel 0 crosses it.
        issue(REQ_WRITE, reg_offset(REG_COUNT), SIZE_WORD, 32'hFFFF_FFFD);
        issue(REQ_WRITE, reg_offset(REG_MATCH0), SIZE_WORD, 32'h0000_0001);
        issue(REQ_WRITE, reg_offset(REG_IRQEN), SIZE_WORD, 32'hFFFF_FFFF);
        repeat (5) issue(REQ_TICK, 16'hFFFF, SIZE_WORD, 32'hFFFF_FFFF);
        issue(REQ_READ, reg_offset(REG_STATUS), SIZE_WORD, 32'h0);
        // A narrow status write merges the set bits back in and clears them.
        issue(REQ_WRITE, reg_offset(REG_STATUS) + 16'd1, SIZE_BYTE, 32'h0);
        issue(REQ_READ, reg_offset(REG_STATUS), SIZE_BYTE, 32'h0);
        issue(REQ_READ, 16'h0020, SIZE_WORD, 32'h0);
        issue(REQ_WRITE, 16'hFFFC, SIZE_WORD, 32'hDEAD_BEEF);
        issue(REQ_IDLE, reg_offset(REG_COUNT), SIZE_WORD, 32'hFFFF_FFFF);
        issue(REQ_READ, reg_offset(REG_IRQEN) + 16'd1, SIZE_ODD, 32'h0);
        issue(REQ_WRITE, reg_offset(REG_WDOG), SIZE_WORD, 32'hFFFF_FFFE);
        issue(REQ_READ, reg_offset(REG_WDOG), SIZE_WORD, 32'h0);
        issue(REQ_TICK, 16'h0000, SIZE_BYTE, 32'h0);
        run_random(250, 1'b0);

        set_divider(16'hFFFF);
        send_idle_pct  = 69;
        recv_stall_pct = 0;
        run_random(150, 1'b0);

        set_divider(16'd3);
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        hold_left      = HOLD_CYCLES;
        run_random(250, 1'b0);

        set_divider(16'd0);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(120, 1'b0);

        set_divider(16'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issue(REQ_WRITE, reg_offset(REG_WDOG), SIZE_WORD, 32'h0000_0001);
        issue(REQ_READ, reg_offset(REG_WDOG), SIZE_WORD, 32'h0);
        issue(REQ_WRITE, reg_offset(REG_STATUS), SIZE_WORD, 32'hFFFF_FFFF);
        issue(REQ_WRITE, reg_offset(REG_IRQEN), SIZE_WORD, 32'h0000_0009);
        issue(REQ_WRITE, reg_offset(REG_MATCH3), SIZE_WORD, scoreboard.counter + 32'd1);
        issue(REQ_WRITE, reg_offset(REG_MATCH0), SIZE_WORD, scoreboard.counter + 32'd1);
        repeat (6) issue(REQ_TICK, 16'h0000, SIZE_WORD, 32'h0);
        issue(REQ_READ, reg_offset(REG_STATUS), SIZE_WORD, 32'h0);
        issue(REQ_WRITE, reg_offset(REG_STATUS), SIZE_WORD, 32'h0000_0009);
        repeat (2) issue(REQ_TICK, 16'h0000, SIZE_WORD, 32'h0);
        run_random(200, 1'b1);

        set_divider(16'($urandom_range(1, 8)));
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(160, 1'b1);

        drain_results();
        repeat (8) @(posedge clk);
        $display("Run covered %0d transfers: %0d ticks, %0d reads, %0d writes, %0d idle codes.",
                 items_sent, scoreboard.n_ticks, scoreboard.n_reads, scoreboard.n_writes,
                 scoreboard.n_idle);
        $display("It saw %0d decode errors, %0d channel hits and %0d watchdog resets %s",
                 scoreboard.n_decode_err, scoreboard.n_hits, scoreboard.n_resets,
                 $sformatf("over %0d dividers.", divider_writes));
        if (scoreboard.mismatches == 0 && scoreboard.expected_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
